### rtl/gth_pkg.sv
// Shared types and constants for the GPIB talker handshake block.
// No dependencies; imported by gpib_talker_handshake_top.
`default_nettype none

package gth_pkg;

  // Command codes carried in the input item
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_DATA  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_TALK_ADDR  = 2'd0;
  localparam logic [1:0] CFG_WAIT_LIMIT = 2'd1;
  localparam logic [1:0] CFG_SETTLE     = 2'd2;
  localparam logic [1:0] CFG_CLEAR_LEN  = 2'd3;

  // Configuration reset values
  localparam logic [4:0]  TALK_ADDR_RST  = 5'd21;
  localparam logic [15:0] WAIT_LIMIT_RST = 16'd1000;
  localparam logic [7:0]  SETTLE_RST     = 8'd1;
  localparam logic [15:0] CLEAR_LEN_RST  = 16'd1000;

  // Bus bytes
  localparam logic [7:0] BYTE_UNL      = 8'h3F;
  localparam logic [7:0] BYTE_UNT      = 8'h5F;
  localparam logic [7:0] BYTE_LAD_BASE = 8'h20;
  localparam logic [7:0] BYTE_TAD_BASE = 8'h40;
  localparam logic [7:0] BYTE_NL       = 8'h0A;
  localparam logic [7:0] BYTE_DCL      = 8'h14;
  localparam logic [7:0] DATA_RELEASED = 8'hFF;

  // Phase codes: context in bits 4:2, handshake step in bits 1:0
  localparam logic [4:0] PH_IDLE  = 5'd0;
  localparam logic [4:0] PH_IFC   = 5'd1;
  localparam logic [4:0] CTX_DCL  = 5'd4;
  localparam logic [4:0] CTX_ADDR = 5'd8;
  localparam logic [4:0] CTX_DATA = 5'd12;
  localparam logic [4:0] CTX_NL   = 5'd16;

  // Handshake steps
  localparam logic [1:0] SUB_WAIT_RFD = 2'd0;
  localparam logic [1:0] SUB_SETTLE   = 2'd1;
  localparam logic [1:0] SUB_WAIT_DAC = 2'd2;
  localparam logic [1:0] SUB_WAIT_END = 2'd3;

  // Handshake outcome for one tick
  localparam logic [1:0] HS_PENDING = 2'd0;
  localparam logic [1:0] HS_SENT    = 2'd1;
  localparam logic [1:0] HS_TIMEOUT = 2'd2;

endpackage

`default_nettype wire

### rtl/gpib_talker_handshake_top.sv
// GPIB talker: source handshake, address cycle and interface clear sequencer.
// Depends on gth_pkg for command codes, phase codes and bus bytes.
// A request is held in the input register; its result is registered in the result register.
// Throughput: one request per cycle while the result stream is not stalled; the talker
// state and the result register are updated together, only when a request is processed.
// Reset: all bus lines released high, phase idle, counters zero, config at defaults.
`default_nettype none

module gpib_talker_handshake_top
  import gth_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  parameter int WAIT_WIDTH  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [4:0] listen_address, [12:5] message_byte, [13] nrfd_high, [14] ndac_high, [15] zero
  input  wire logic [15:0] s_axis_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  s_axis_tuser,
  // final_byte
  input  wire logic        s_axis_tlast,
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] data_lines, [8] dav_level, [9] atn_level, [10] eoi_level, [11] ifc_level,
  // [12] ready_res, [13] done_res, [14] failed, [15] rejected, [31:16] bytes_sent
  output logic [31:0]      m_axis_tdata
);

  localparam int CMP_W = (WAIT_WIDTH > 16) ? WAIT_WIDTH : 16;
  localparam int BS_W  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [WAIT_WIDTH-1:0]  WAIT_MAX  = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // configuration
  logic [4:0]  talk_addr_q;
  logic [15:0] wait_limit_q;
  logic [7:0]  settle_q;
  logic [15:0] clear_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      talk_addr_q  <= TALK_ADDR_RST;
      wait_limit_q <= WAIT_LIMIT_RST;
      settle_q     <= SETTLE_RST;
      clear_len_q  <= CLEAR_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_TALK_ADDR:  talk_addr_q  <= cfg_wdata_i[4:0];
        CFG_WAIT_LIMIT: wait_limit_q <= cfg_wdata_i;
        CFG_SETTLE:     settle_q     <= cfg_wdata_i[7:0];
        CFG_CLEAR_LEN:  clear_len_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  logic     in_valid_q;
  opcode_e  op_q;
  logic [4:0] la_q;
  logic [7:0] mb_q;
  logic     fin_q;
  logic     nrfd_q;
  logic     ndac_q;
  logic     proc;
  logic     out_valid_q;

  assign proc          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || proc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q   <= opcode_e'(s_axis_tuser);
      la_q   <= s_axis_tdata[4:0];
      mb_q   <= s_axis_tdata[12:5];
      nrfd_q <= s_axis_tdata[13];
      ndac_q <= s_axis_tdata[14];
      fin_q  <= s_axis_tlast;
    end
  end

  // talker state
  logic [4:0]             phase_q, phase_d;
  logic [WAIT_WIDTH-1:0]  wc_q, wc_d, wc_bump;
  logic [7:0]             cur_q, cur_d;
  logic [2:0]             step_q, step_d;
  logic [4:0]             lis_q, lis_d;
  logic [COUNT_WIDTH-1:0] mc_q, mc_d;
  logic                   pf_q, pf_d;
  logic                   mo_q, mo_d;
  logic [7:0]             data_q, data_d;
  logic                   dav_q, dav_d, atn_q, atn_d, eoi_q, eoi_d, ifc_q, ifc_d;
  logic                   done, failed, rejected;
  logic [1:0]             hs;
  logic                   reach_wait, reach_settle, reach_clear;
  logic [4:0]             base;
  logic [BS_W-1:0]        mc_ext;
  logic [15:0]            bytes_sent;

  assign wc_bump      = (wc_q == WAIT_MAX) ? wc_q : wc_q + 1'b1;
  assign reach_wait   = (CMP_W'(wc_bump) >= CMP_W'(wait_limit_q)) || (wc_bump == WAIT_MAX);
  assign reach_settle = (CMP_W'(wc_bump) >= CMP_W'(settle_q)) || (wc_bump == WAIT_MAX);
  assign reach_clear  = (CMP_W'(wc_bump) >= CMP_W'(clear_len_q)) || (wc_bump == WAIT_MAX);
  assign base         = {phase_q[4:2], 2'b00};

  always_comb begin
    phase_d  = phase_q;
    wc_d     = wc_q;
    cur_d    = cur_q;
    step_d   = step_q;
    lis_d    = lis_q;
    mc_d     = mc_q;
    pf_d     = pf_q;
    mo_d     = mo_q;
    data_d   = data_q;
    dav_d    = dav_q;
    atn_d    = atn_q;
    eoi_d    = eoi_q;
    ifc_d    = ifc_q;
    done     = 1'b0;
    failed   = 1'b0;
    rejected = 1'b0;
    hs       = HS_PENDING;

    if (phase_q == PH_IDLE) begin
      case (op_q)
        OP_CLEAR: begin
          mo_d    = 1'b0;
          mc_d    = '0;
          pf_d    = 1'b0;
          ifc_d   = 1'b0;
          wc_d    = '0;
          phase_d = PH_IFC;
        end
        OP_START: begin
          lis_d   = la_q;
          step_d  = 3'd0;
          atn_d   = 1'b0;
          cur_d   = BYTE_UNL;
          wc_d    = '0;
          phase_d = CTX_ADDR;
        end
        OP_DATA: begin
          if (mo_q) begin
            pf_d    = fin_q;
            cur_d   = mb_q;
            wc_d    = '0;
            phase_d = CTX_DATA;
          end else begin
            rejected = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      if (op_q != OP_TICK) rejected = 1'b1;
      if (phase_q == PH_IFC) begin
        wc_d = wc_bump;
        if (reach_clear) begin
          // end the clear pulse, then send DCL under ATN
          ifc_d   = 1'b1;
          atn_d   = 1'b0;
          cur_d   = BYTE_DCL;
          wc_d    = '0;
          phase_d = CTX_DCL;
        end
      end else begin
        case (phase_q[1:0])
          SUB_WAIT_RFD: begin
            if (nrfd_q) begin
              data_d = ~cur_q;
              wc_d   = '0;
              if (settle_q == 8'd0) begin
                dav_d   = 1'b0;
                phase_d = {phase_q[4:2], SUB_WAIT_DAC};
              end else begin
                phase_d = {phase_q[4:2], SUB_SETTLE};
              end
            end else begin
              wc_d = wc_bump;
              if (reach_wait) hs = HS_TIMEOUT;
            end
          end
          SUB_SETTLE: begin
            wc_d = wc_bump;
            if (reach_settle) begin
              dav_d   = 1'b0;
              wc_d    = '0;
              phase_d = {phase_q[4:2], SUB_WAIT_DAC};
            end
          end
          SUB_WAIT_DAC: begin
            if (ndac_q) begin
              dav_d   = 1'b1;
              data_d  = DATA_RELEASED;
              wc_d    = '0;
              phase_d = {phase_q[4:2], SUB_WAIT_END};
            end else begin
              wc_d = wc_bump;
              if (reach_wait) begin
                dav_d  = 1'b1;
                data_d = DATA_RELEASED;
                hs     = HS_TIMEOUT;
              end
            end
          end
          default: begin
            if (nrfd_q) begin
              hs = HS_SENT;
            end else begin
              wc_d = wc_bump;
              if (reach_wait) hs = HS_TIMEOUT;
            end
          end
        endcase

        if (hs != HS_PENDING) begin
          unique case (base)
            CTX_DCL: begin
              atn_d   = 1'b1;
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
            CTX_ADDR: begin
              // timeouts in the address cycle are ignored: advance anyway
              step_d = step_q + 3'd1;
              wc_d   = '0;
              case (step_d)
                3'd1: begin
                  cur_d   = BYTE_UNT;
                  phase_d = CTX_ADDR;
                end
                3'd2: begin
                  cur_d   = BYTE_LAD_BASE | {3'b000, lis_q};
                  phase_d = CTX_ADDR;
                end
                3'd3: begin
                  cur_d   = BYTE_TAD_BASE | {3'b000, talk_addr_q};
                  phase_d = CTX_ADDR;
                end
                default: begin
                  wc_d    = wc_q;
                  if (hs == HS_TIMEOUT || phase_q[1:0] != SUB_WAIT_END || !nrfd_q) wc_d = wc_bump;
                  if (hs == HS_SENT) wc_d = wc_q;
                  atn_d   = 1'b1;
                  mo_d    = 1'b1;
                  mc_d    = '0;
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end
              endcase
            end
            CTX_DATA: begin
              if (hs == HS_SENT) begin
                if (mc_q != COUNT_MAX) mc_d = mc_q + 1'b1;
                if (pf_q) begin
                  pf_d    = 1'b0;
                  eoi_d   = 1'b0;
                  cur_d   = BYTE_NL;
                  wc_d    = '0;
                  phase_d = CTX_NL;
                end else begin
                  phase_d = PH_IDLE;
                  done    = 1'b1;
                end
              end else begin
                pf_d    = 1'b0;
                mo_d    = 1'b0;
                phase_d = PH_IDLE;
                done    = 1'b1;
                failed  = 1'b1;
              end
            end
            CTX_NL: begin
              // timeout on the closing NL is not reported
              eoi_d   = 1'b1;
              mo_d    = 1'b0;
              phase_d = PH_IDLE;
              done    = 1'b1;
            end
            default: ;
          endcase
        end
      end
    end
  end

  assign mc_ext     = BS_W'(mc_d);
  assign bytes_sent = (mc_ext > BS_W'(16'hFFFF)) ? 16'hFFFF : mc_ext[15:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      wc_q    <= '0;
      cur_q   <= '0;
      step_q  <= '0;
      lis_q   <= '0;
      mc_q    <= '0;
      pf_q    <= 1'b0;
      mo_q    <= 1'b0;
      data_q  <= DATA_RELEASED;
      dav_q   <= 1'b1;
      atn_q   <= 1'b1;
      eoi_q   <= 1'b1;
      ifc_q   <= 1'b1;
    end else if (proc) begin
      phase_q <= phase_d;
      wc_q    <= wc_d;
      cur_q   <= cur_d;
      step_q  <= step_d;
      lis_q   <= lis_d;
      mc_q    <= mc_d;
      pf_q    <= pf_d;
      mo_q    <= mo_d;
      data_q  <= data_d;
      dav_q   <= dav_d;
      atn_q   <= atn_d;
      eoi_q   <= eoi_d;
      ifc_q   <= ifc_d;
    end
  end

  // result register
  logic [31:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_data_q <= {bytes_sent, rejected, failed, done, (phase_d == PH_IDLE),
                     ifc_d, eoi_d, atn_d, dav_d, data_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // IFC is only driven low during the clear pulse
  a_ifc_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ifc_q |-> phase_q == PH_IFC)
    else $error("IFC asserted outside the clear pulse");

  // EOI is only driven low while the closing NL is on the bus
  a_eoi_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !eoi_q |-> phase_q[4:2] == CTX_NL[4:2])
    else $error("EOI asserted outside the closing NL");

  // DAV low only while waiting for data accepted
  a_dav_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dav_q |-> (phase_q[1:0] == SUB_WAIT_DAC && phase_q[4:2] != 3'd0))
    else $error("DAV asserted outside the accept wait");

  // a failure is always reported together with done
  a_fail_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[14] |-> out_data_q[13])
    else $error("failed without done");

endmodule

`default_nettype wire

### sim/tb_top.sv
// Self-checking bench for gpib_talker_handshake_top: drives bus ticks, predicts the line levels.
// Depends on gth_pkg (opcodes, phase codes, bus bytes) and the RTL top level only.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gth_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200_000;

  // bit positions inside the predicted bus line vector
  localparam int LN_DAV = 8;
  localparam int LN_ATN = 9;
  localparam int LN_EOI = 10;
  localparam int LN_IFC = 11;

  typedef struct packed {
    opcode_e    op;
    logic [4:0] la;
    logic [7:0] mb;
    logic       fin;
    logic       nrfd;
    logic       ndac;
  } tick_item_t;

  // same layout as m_axis_tdata
  typedef struct packed {
    logic [15:0] bytes_sent;
    logic        rejected;
    logic        failed;
    logic        done;
    logic        ready;
    logic        ifc;
    logic        eoi;
    logic        atn;
    logic        dav;
    logic [7:0]  data_lines;
  } bus_result_t;

  typedef struct packed {
    tick_item_t  item;
    logic        typed;
    bus_result_t want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_TALK_ADDR;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = OP_TICK;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  gpib_talker_handshake_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // talker state as predicted, at reset values
  logic [4:0]  bus_phase = PH_IDLE;
  logic [15:0] hold_count = '0;
  logic [7:0]  tx_byte = '0;
  logic [2:0]  addr_step = '0;
  logic [4:0]  listen_addr = '0;
  logic [15:0] sent_count = '0;
  logic        final_pending = 1'b0;
  logic        msg_open = 1'b0;
  logic [11:0] bus_lines = 12'hFFF;

  logic [4:0]  cfg_talk = TALK_ADDR_RST;
  logic [15:0] cfg_wait = WAIT_LIMIT_RST;
  logic [7:0]  cfg_settle = SETTLE_RST;
  logic [15:0] cfg_clear = CLEAR_LEN_RST;

  bus_result_t bus_state_due[$];
  plan_row_t   directed_plan[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned line_bias = 90;
  bit          sender_gapless = 1'b0;
  bit          long_stall_req = 1'b0;
  bus_result_t seen_state, due_state;

  function automatic void bump_hold();
    if (hold_count != 16'hFFFF) hold_count++;
  endfunction

  function automatic logic limit_hit(input logic [15:0] limit);
    return (hold_count >= limit) || (hold_count == 16'hFFFF);
  endfunction

  function automatic void load_byte(input logic [4:0] ctx, input logic [7:0] b);
    tx_byte    = b;
    hold_count = '0;
    bus_phase  = ctx;
  endfunction

  // one tick of the source handshake on the byte in tx_byte
  function automatic logic [1:0] source_handshake(input logic nrfd, input logic ndac);
    case (bus_phase[1:0])
      SUB_WAIT_RFD: begin
        if (nrfd) begin
          bus_lines[7:0] = ~tx_byte;
          hold_count = '0;
          if (cfg_settle == 8'd0) begin
            bus_lines[LN_DAV] = 1'b0;
            bus_phase = {bus_phase[4:2], SUB_WAIT_DAC};
          end else begin
            bus_phase = {bus_phase[4:2], SUB_SETTLE};
          end
          return HS_PENDING;
        end
        bump_hold();
        return limit_hit(cfg_wait) ? HS_TIMEOUT : HS_PENDING;
      end
      SUB_SETTLE: begin
        bump_hold();
        if (limit_hit({8'd0, cfg_settle})) begin
          bus_lines[LN_DAV] = 1'b0;
          hold_count = '0;
          bus_phase = {bus_phase[4:2], SUB_WAIT_DAC};
        end
        return HS_PENDING;
      end
      SUB_WAIT_DAC: begin
        if (ndac) begin
          bus_lines[LN_DAV] = 1'b1;
          bus_lines[7:0] = DATA_RELEASED;
          hold_count = '0;
          bus_phase = {bus_phase[4:2], SUB_WAIT_END};
          return HS_PENDING;
        end
        bump_hold();
        if (limit_hit(cfg_wait)) begin
          bus_lines[LN_DAV] = 1'b1;
          bus_lines[7:0] = DATA_RELEASED;
          return HS_TIMEOUT;
        end
        return HS_PENDING;
      end
      default: begin
        if (nrfd) return HS_SENT;
        bump_hold();
        return limit_hit(cfg_wait) ? HS_TIMEOUT : HS_PENDING;
      end
    endcase
  endfunction

  // advance the talker by one accepted tick and return the bus levels it shows
  function automatic bus_result_t predict_bus(input tick_item_t it);
    bus_result_t r;
    logic [4:0]  ctx;
    logic [1:0]  hs;
    r = '0;
    if (bus_phase == PH_IDLE) begin
      case (it.op)
        OP_CLEAR: begin
          msg_open = 1'b0;
          sent_count = '0;
          final_pending = 1'b0;
          bus_lines[LN_IFC] = 1'b0;
          hold_count = '0;
          bus_phase = PH_IFC;
        end
        OP_START: begin
          listen_addr = it.la;
          addr_step = '0;
          bus_lines[LN_ATN] = 1'b0;
          load_byte(CTX_ADDR, BYTE_UNL);
        end
        OP_DATA: begin
          if (msg_open) begin
            final_pending = it.fin;
            load_byte(CTX_DATA, it.mb);
          end else begin
            r.rejected = 1'b1;
          end
        end
        default: ;
      endcase
    end else begin
      if (it.op != OP_TICK) r.rejected = 1'b1;
      if (bus_phase == PH_IFC) begin
        bump_hold();
        if (limit_hit(cfg_clear)) begin
          bus_lines[LN_IFC] = 1'b1;
          bus_lines[LN_ATN] = 1'b0;
          load_byte(CTX_DCL, BYTE_DCL);
        end
      end else begin
        ctx = {bus_phase[4:2], 2'b00};
        hs = source_handshake(it.nrfd, it.ndac);
        if (hs != HS_PENDING) begin
          if (ctx == CTX_DCL) begin
            bus_lines[LN_ATN] = 1'b1;
            bus_phase = PH_IDLE;
            r.done = 1'b1;
          end else if (ctx == CTX_ADDR) begin
            // address bytes go out regardless of how the handshake ended
            addr_step = addr_step + 3'd1;
            case (addr_step)
              3'd1: load_byte(CTX_ADDR, BYTE_UNT);
              3'd2: load_byte(CTX_ADDR, BYTE_LAD_BASE | {3'b000, listen_addr});
              3'd3: load_byte(CTX_ADDR, BYTE_TAD_BASE | {3'b000, cfg_talk});
              default: begin
                bus_lines[LN_ATN] = 1'b1;
                msg_open = 1'b1;
                sent_count = '0;
                bus_phase = PH_IDLE;
                r.done = 1'b1;
              end
            endcase
          end else if (ctx == CTX_DATA) begin
            if (hs == HS_SENT) begin
              if (sent_count != 16'hFFFF) sent_count++;
              if (final_pending) begin
                final_pending = 1'b0;
                bus_lines[LN_EOI] = 1'b0;
                load_byte(CTX_NL, BYTE_NL);
              end else begin
                bus_phase = PH_IDLE;
                r.done = 1'b1;
              end
            end else begin
              // timed-out data byte aborts the message
              final_pending = 1'b0;
              msg_open = 1'b0;
              bus_phase = PH_IDLE;
              r.done = 1'b1;
              r.failed = 1'b1;
            end
          end else begin
            // closing NL: a timeout here is not reported
            bus_lines[LN_EOI] = 1'b1;
            msg_open = 1'b0;
            bus_phase = PH_IDLE;
            r.done = 1'b1;
          end
        end
      end
    end
    r.data_lines = bus_lines[7:0];
    r.dav = bus_lines[LN_DAV];
    r.atn = bus_lines[LN_ATN];
    r.eoi = bus_lines[LN_EOI];
    r.ifc = bus_lines[LN_IFC];
    r.ready = (bus_phase == PH_IDLE);
    r.bytes_sent = sent_count;
    return r;
  endfunction

  function automatic void add_row(input opcode_e op, input logic [4:0] la,
                                  input logic [7:0] mb, input logic fin,
                                  input logic nrfd, input logic ndac,
                                  input logic typed = 1'b0, input logic [31:0] want = '0);
    plan_row_t row;
    row.item = '{op: op, la: la, mb: mb, fin: fin, nrfd: nrfd, ndac: ndac};
    row.typed = typed;
    row.want = want;
    directed_plan.push_back(row);
  endfunction

  // mostly well-formed traffic for the current talker state, some noise
  function automatic tick_item_t random_item();
    tick_item_t  it;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    it.la = 5'($urandom);
    it.mb = 8'($urandom);
    it.fin = ($urandom_range(0, 4) == 0);
    it.nrfd = ($urandom_range(0, 99) < line_bias);
    it.ndac = ($urandom_range(0, 99) < line_bias);
    if (bus_phase != PH_IDLE)
      it.op = (pick < 92) ? OP_TICK : opcode_e'($urandom_range(1, 3));
    else if (msg_open)
      it.op = (pick < 75) ? OP_DATA : (pick < 85) ? OP_START :
              (pick < 88) ? OP_CLEAR : OP_TICK;
    else
      it.op = (pick < 70) ? OP_START : (pick < 74) ? OP_CLEAR :
              (pick < 86) ? OP_DATA : OP_TICK;
    // skip long clear pulses so the run length stays bounded
    if (bus_phase == PH_IDLE && it.op == OP_CLEAR && cfg_clear > 16'd64)
      it.op = OP_TICK;
    return it;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic offer(input tick_item_t it, input logic typed, input bus_result_t want);
    int unsigned gap;
    int unsigned pick;
    bus_result_t due;
    pick = $urandom_range(0, 99);
    gap = sender_gapless ? 0 : (pick < 60) ? 0 : (pick < 95) ? $urandom_range(1, 3) :
          $urandom_range(8, 30);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.ndac, it.nrfd, it.mb, it.la};
    s_axis_tuser  <= it.op;
    s_axis_tlast  <= it.fin;
    do @(posedge clk_i); while (!s_axis_tready);
    due = predict_bus(it);
    bus_state_due.push_back(typed ? want : due);
    @(negedge clk_i);
  endtask

  // bring the talker to idle, let the pipe empty, then write every register
  task automatic load_config(input logic [4:0] talk, input logic [15:0] wait_lim,
                             input logic [7:0] settle, input logic [15:0] clr);
    tick_item_t quiet;
    bit         prev_gapless;
    prev_gapless = sender_gapless;
    sender_gapless = 1'b1;
    while (bus_phase != PH_IDLE) begin
      quiet = '{op: OP_TICK, la: 5'($urandom), mb: 8'($urandom), fin: 1'b0,
                nrfd: 1'b1, ndac: 1'b1};
      offer(quiet, 1'b0, '0);
    end
    sender_gapless = prev_gapless;
    s_axis_tvalid <= 1'b0;
    while (bus_state_due.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_TALK_ADDR;
    cfg_wdata_i <= {11'd0, talk};
    @(negedge clk_i);
    cfg_index_i <= CFG_WAIT_LIMIT;
    cfg_wdata_i <= wait_lim;
    @(negedge clk_i);
    cfg_index_i <= CFG_SETTLE;
    cfg_wdata_i <= {8'd0, settle};
    @(negedge clk_i);
    cfg_index_i <= CFG_CLEAR_LEN;
    cfg_wdata_i <= clr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_talk = talk;
    cfg_wait = wait_lim;
    cfg_settle = settle;
    cfg_clear = clr;
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) offer(random_item(), 1'b0, '0);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short timeouts so every wait can expire within a few ticks
    load_config(5'd31, 16'd1, 8'd0, 16'd1);
    add_row(OP_TICK,  5'd0,  8'h00, 1'b0, 1'b1, 1'b1, 1'b1, 32'h0000_1FFF);
    add_row(OP_DATA,  5'd0,  8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0000_9FFF);
    add_row(OP_START, 5'd31, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 32'h0000_0DFF);
    repeat (4) add_row(OP_TICK, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(OP_DATA,  5'd0,  8'h00, 1'b0, 1'b1, 1'b1);
    add_row(OP_START, 5'd5,  8'h00, 1'b0, 1'b1, 1'b0);
    add_row(OP_TICK,  5'd0,  8'h00, 1'b0, 1'b0, 1'b1);
    add_row(OP_TICK,  5'd0,  8'h00, 1'b0, 1'b1, 1'b0);
    add_row(OP_START, 5'd0,  8'h00, 1'b0, 1'b0, 1'b0);
    repeat (4) add_row(OP_TICK, 5'd0, 8'h00, 1'b0, 1'b0, 1'b0);
    add_row(OP_DATA,  5'd0,  8'hFF, 1'b1, 1'b1, 1'b1);
    add_row(OP_TICK,  5'd0,  8'h00, 1'b0, 1'b1, 1'b0);
    add_row(OP_TICK,  5'd0,  8'h00, 1'b0, 1'b0, 1'b1);
    add_row(OP_TICK,  5'd0,  8'h00, 1'b0, 1'b1, 1'b1);
    add_row(OP_TICK,  5'd0,  8'h00, 1'b0, 1'b0, 1'b0);
    add_row(OP_CLEAR, 5'd0,  8'h00, 1'b0, 1'b1, 1'b1);
    add_row(OP_DATA,  5'd0,  8'h5A, 1'b0, 1'b1, 1'b1);
    add_row(OP_TICK,  5'd0,  8'h00, 1'b0, 1'b0, 1'b0);
    foreach (directed_plan[i])
      offer(directed_plan[i].item, directed_plan[i].typed, directed_plan[i].want);

    line_bias = 90;
    load_config(TALK_ADDR_RST, WAIT_LIMIT_RST, SETTLE_RST, CLEAR_LEN_RST);
    run_random(200);

    line_bias = 70;
    load_config(5'd0, 16'd0, 8'd0, 16'd0);
    run_random(200);

    line_bias = 70;
    load_config(5'd30, 16'd3, 8'd2, 16'd2);
    long_stall_req = 1'b1;
    run_random(220);

    line_bias = 85;
    load_config(5'd31, 16'hFFFF, 8'hFF, 16'hFFFF);
    run_random(150);

    line_bias = 75;
    load_config(5'd7, 16'd8, 8'd4, 16'd5);
    long_stall_req = 1'b1;
    run_random(220);

    line_bias = 60;
    sender_gapless = 1'b1;
    load_config(5'd16, 16'd1, 8'd0, 16'd1);
    run_random(220);
    sender_gapless = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (bus_state_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: alternate ready and stall stretches, one long hold on request
  initial begin : result_sink
    int unsigned len;
    int unsigned pick;
    forever begin
      @(negedge clk_i);
      pick = $urandom_range(0, 99);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        m_axis_tready <= 1'b0;
        len = 600;
      end else if (m_axis_tready) begin
        m_axis_tready <= 1'b0;
        len = (pick < 80) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end else begin
        m_axis_tready <= 1'b1;
        len = (pick < 85) ? $urandom_range(1, 12) : $urandom_range(100, 300);
      end
      repeat (len - 1) @(negedge clk_i);
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen_state = m_axis_tdata;
      if (bus_state_due.size() == 0) begin
        mismatches++;
        $display("%0t: result %h with no request outstanding, expected none",
                 $time, m_axis_tdata);
      end else begin
        due_state = bus_state_due.pop_front();
        check_field("data_lines", due_state.data_lines, seen_state.data_lines);
        check_field("dav_level", due_state.dav, seen_state.dav);
        check_field("atn_level", due_state.atn, seen_state.atn);
        check_field("eoi_level", due_state.eoi, seen_state.eoi);
        check_field("ifc_level", due_state.ifc, seen_state.ifc);
        check_field("ready", due_state.ready, seen_state.ready);
        check_field("done", due_state.done, seen_state.done);
        check_field("failed", due_state.failed, seen_state.failed);
        check_field("rejected", due_state.rejected, seen_state.rejected);
        check_field("bytes_sent", due_state.bytes_sent, seen_state.bytes_sent);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, bus_state_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

endmodule
